// ===== sv/rpid_pkg.sv =====
`default_nettype none
package rpid_pkg;

  // Widest id that the block produces.
  localparam int unsigned WordWidth = 32;
  localparam int unsigned CntW = $clog2(32);
  localparam logic [6:0] JTries = 7'd64;

  typedef enum logic [2:0] {
    CfgIdBits     = 3'd0,
    CfgCycleLimit = 3'd1,
    CfgPrimeMod   = 3'd2,
    CfgBaseGen    = 3'd3,
    CfgLcgMod     = 3'd4,
    CfgMultBase   = 3'd5,
    CfgInterval   = 3'd6,
    CfgLargeFact  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [5:0]  id_bits;
    logic [31:0] cycle_limit;
    logic [31:0] prime_modulus;
    logic [31:0] base_generator;
    logic [31:0] lcg_modulus;
    logic [31:0] multiplier_base;
    logic [15:0] reseed_interval;
    logic [31:0] large_factor;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_seconds;
    logic [1:0]  skip_word;
    logic [31:0] rand_state;
    logic [31:0] rand_seed_out;
    logic [31:0] rand_seed_exp;
    logic [31:0] rand_increment;
    logic [31:0] rand_mult_exp;
    logic [31:0] rand_gen_exp;
  } req_t;

  typedef struct packed {
    logic [31:0] id_value;
    logic        did_reseed;
  } rsp_t;

  // A modulus register of zero stands for 2^32.
  function automatic logic [32:0] mod33(logic [31:0] v);
    return (v == 32'd0) ? 33'h1_0000_0000 : {1'b0, v};
  endfunction

  function automatic logic [5:0] sat_bits(logic [5:0] b);
    if (b < 6'd2) return 6'd2;
    if (b > 6'(WordWidth)) return 6'(WordWidth);
    return b;
  endfunction

  function automatic logic [31:0] low_mask(logic [5:0] b);
    logic [32:0] m;
    m = (33'd1 << b) - 33'd1;
    return m[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/rpid_if.sv =====
`default_nettype none
interface rpid_req_if import rpid_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rpid_rsp_if import rpid_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/rpid_mulmod.sv =====
`default_nettype none
// Bit-serial modular multiplier: first reduces a_i by m_i, then forms
// x_i * a mod m_i one bit of x_i per cycle, most significant bit first.
module rpid_mulmod import rpid_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] x_i,
  input  wire logic [31:0] a_i,
  input  wire logic [32:0] m_i,
  output logic             done_o,
  output logic [31:0]      r_o
);

  logic            busy_q, ph_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0]     sh_q, x_q, ra_q, r_q;
  logic [32:0]     m_q;
  logic            bit_s;
  logic [33:0]     add_s, m34, t0, t1, t2, t3;

  always_comb begin
    bit_s = ph_q ? x_q[31] : sh_q[31];
    add_s = ph_q ? {2'b0, ra_q} : 34'd1;
    m34   = {1'b0, m_q};
    t0    = {1'b0, r_q, 1'b0};
    t1    = (t0 >= m34) ? t0 - m34 : t0;
    t2    = bit_s ? t1 + add_s : t1;
    t3    = (t2 >= m34) ? t2 - m34 : t2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ph_q   <= 1'b0;
        cnt_q  <= CntW'(31);
        sh_q   <= a_i;
        x_q    <= x_i;
        m_q    <= m_i;
        r_q    <= '0;
      end else if (busy_q) begin
        r_q   <= t3[31:0];
        cnt_q <= cnt_q - CntW'(1);
        if (ph_q) x_q <= {x_q[30:0], 1'b0};
        else sh_q <= {sh_q[30:0], 1'b0};
        if (cnt_q == '0) begin
          if (!ph_q) begin
            ra_q  <= t3[31:0];
            r_q   <= '0;
            ph_q  <= 1'b1;
            cnt_q <= CntW'(31);
          end else begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule
`default_nettype wire

// ===== sv/rpid_ctrl.sv =====
`default_nettype none
// Sequencer: reseed, coprime search, LCG steps and modular powers, all
// built on one shared serial multiplier.
module rpid_ctrl import rpid_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic start_i,
  input  wire req_t req_i,
  input  wire logic slot_free_i,
  output logic      done_o,
  output rsp_t      rsp_o,
  output logic      idle_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RX, S_RB, S_RJ0, S_RJ, S_RJ3, S_RJL,
    S_PINIT, S_PMUL, S_PSQ, S_LI, S_LM, S_OUT
  } state_e;

  typedef enum logic [1:0] {RET_A, RET_G, RET_ID} ret_e;

  state_e      state_q;
  ret_e        ret_q;
  req_t        req_q;
  rsp_t        rsp_q;
  logic [5:0]  bits_q;
  logic [1:0]  left_q;
  logic        did_q, top_q, pend_q;
  logic [31:0] lcg_q, oseed_q, eseed_q, mult_q, incr_q, gen_q, cnt_q, dl_q;
  logic [31:0] b_q, j_q, pb_q, pe_q, ps_q, pt_q, t1_q;
  logic [32:0] pm_q;
  logic [6:0]  tries_q;

  logic        need_mul, mul_go, mul_done, ok, pw_ret, need_rs;
  logic [31:0] mx, ma, mul_r, pw_s, j_inc, lsum, idv;
  logic [32:0] mm, lcgm, pn, jp1, sum33;
  logic [5:0]  bits_eff;

  assign lcgm     = mod33(cfg_i.lcg_modulus);
  assign pn       = mod33(cfg_i.prime_modulus);
  assign bits_eff = sat_bits(cfg_i.id_bits);

  always_comb begin
    need_mul = 1'b1;
    mx = '0;
    ma = 32'd1;
    mm = lcgm;
    case (state_q)
      S_RX:    mx = req_q.rand_state;
      S_RB:    begin mx = b_q; mm = 33'd3; end
      S_PINIT: begin mx = pb_q; mm = pm_q; end
      S_PMUL:  begin
        need_mul = (pe_q != '0) && pe_q[0];
        mx = ps_q; ma = pt_q; mm = pm_q;
      end
      S_PSQ:   begin mx = pt_q; ma = pt_q; mm = pm_q; end
      S_RJ0:   begin mx = req_q.rand_gen_exp; mm = pn; end
      S_RJ3:   begin mx = j_q; mm = 33'd3; end
      S_RJL:   begin mx = j_q; mm = {1'b0, cfg_i.large_factor}; end
      S_LI:    mx = incr_q;
      S_LM:    begin mx = mult_q; ma = lcg_q; end
      default: need_mul = 1'b0;
    endcase
    mul_go = need_mul && !pend_q;
    ok     = pend_q && mul_done;
  end

  rpid_mulmod u_mul (
    .clk_i, .rst_ni, .start_i(mul_go), .x_i(mx), .a_i(ma), .m_i(mm),
    .done_o(mul_done), .r_o(mul_r)
  );

  always_comb begin
    need_rs = (cnt_q >= cfg_i.cycle_limit) || (req_i.now_seconds > dl_q) ||
              (({1'b0, cnt_q} + {31'b0, req_i.skip_word}) >= {1'b0, cfg_i.cycle_limit});
    jp1   = {1'b0, j_q} + 33'd1;
    j_inc = (jp1 == pn) ? 32'd0 : jp1[31:0];
    sum33 = {1'b0, mul_r} + {1'b0, t1_q};
    lsum  = (sum33 >= lcgm) ? 32'(sum33 - lcgm) : sum33[31:0];
    pw_s  = (pe_q == '0) ? ps_q : mul_r;
    pw_ret = (state_q == S_PMUL) &&
             ((pe_q == '0) || (pe_q[0] && ok && (pe_q[31:1] == '0)));
    idv = oseed_q ^ pw_s;
    if (top_q) idv = idv | (32'd1 << (bits_q - 6'd1));
    idv = idv & low_mask(bits_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= RET_A;
      pend_q  <= 1'b0;
      lcg_q <= '0; oseed_q <= '0; eseed_q <= '0; mult_q <= '0;
      incr_q <= '0; gen_q <= '0; cnt_q <= '0; dl_q <= '0; top_q <= 1'b0;
    end else begin
      if (mul_go) pend_q <= 1'b1;
      else if (ok) pend_q <= 1'b0;
      if (pw_ret) begin
        unique case (ret_q)
          RET_A: begin mult_q <= pw_s; state_q <= S_RJ0; end
          RET_G: begin gen_q <= pw_s; state_q <= S_LI; end
          default: begin
            rsp_q.id_value   <= idv;
            rsp_q.did_reseed <= did_q;
            state_q <= S_OUT;
          end
        endcase
      end
      unique case (state_q)
        S_IDLE: if (start_i) begin
          req_q  <= req_i;
          bits_q <= bits_eff;
          left_q <= req_i.skip_word;
          did_q  <= need_rs;
          cnt_q  <= (need_rs ? 32'd0 : cnt_q) + {30'b0, req_i.skip_word} + 32'd1;
          if (need_rs) begin
            oseed_q <= req_i.rand_seed_out & low_mask(bits_eff - 6'd1);
            eseed_q <= req_i.rand_seed_exp & low_mask(bits_eff - 6'd1);
            b_q     <= (req_i.rand_increment & low_mask(bits_eff)) | 32'd1;
            dl_q    <= req_i.now_seconds + {16'b0, cfg_i.reseed_interval};
            top_q   <= !top_q;
            state_q <= S_RX;
          end else begin
            state_q <= S_LI;
          end
        end
        S_RX: if (ok) begin lcg_q <= mul_r; state_q <= S_RB; end
        S_RB: if (ok) begin
          incr_q  <= (mul_r == '0) ? b_q + 32'd2 : b_q;
          pb_q    <= cfg_i.multiplier_base;
          pe_q    <= req_q.rand_mult_exp & low_mask(bits_q) & 32'hFFFF_FFFE;
          pm_q    <= lcgm;
          ret_q   <= RET_A;
          state_q <= S_PINIT;
        end
        S_PINIT: if (ok) begin pt_q <= mul_r; ps_q <= 32'd1; state_q <= S_PMUL; end
        S_PMUL: if (pe_q != '0) begin
          if (!pe_q[0]) state_q <= S_PSQ;
          else if (ok) begin
            ps_q <= mul_r;
            if (pe_q[31:1] != '0) state_q <= S_PSQ;
          end
        end
        S_PSQ: if (ok) begin
          pt_q <= mul_r; pe_q <= pe_q >> 1; state_q <= S_PMUL;
        end
        S_RJ0: if (ok) begin j_q <= mul_r; tries_q <= 7'd1; state_q <= S_RJ; end
        S_RJ: begin
          if (tries_q == JTries) begin
            pb_q <= cfg_i.base_generator; pe_q <= j_q; pm_q <= pn;
            ret_q <= RET_G; state_q <= S_PINIT;
          end else if (!j_q[0]) begin
            j_q <= j_inc; tries_q <= tries_q + 7'd1;
          end else begin
            state_q <= S_RJ3;
          end
        end
        S_RJ3, S_RJL: if (ok) begin
          if (mul_r == '0) begin
            j_q <= j_inc; tries_q <= tries_q + 7'd1; state_q <= S_RJ;
          end else if (state_q == S_RJ3 && cfg_i.large_factor != '0) begin
            state_q <= S_RJL;
          end else begin
            pb_q <= cfg_i.base_generator; pe_q <= j_q; pm_q <= pn;
            ret_q <= RET_G; state_q <= S_PINIT;
          end
        end
        S_LI: if (ok) begin t1_q <= mul_r; state_q <= S_LM; end
        S_LM: if (ok) begin
          lcg_q <= lsum;
          if (left_q == 2'd0) begin
            pb_q <= gen_q; pe_q <= eseed_q ^ lsum; pm_q <= pn;
            ret_q <= RET_ID; state_q <= S_PINIT;
          end else begin
            left_q <= left_q - 2'd1; state_q <= S_LI;
          end
        end
        S_OUT: if (slot_free_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == S_OUT) && slot_free_i;
  assign rsp_o  = rsp_q;
  assign idle_o = (state_q == S_IDLE);

endmodule
`default_nettype wire

// ===== sv/random_packet_id_generator.sv =====
`default_nettype none
// Random packet id generator. One request item gives one result item; the
// block works on one item at a time and takes the next item while the last
// result still waits at the output. All modular products run through one
// bit-serial modular multiplier, which reduces one operand first and then
// multiplies. An item without reseed costs (skip+1) LCG steps of two
// products each plus one modular power of one setup product and up to two
// products per exponent bit. An item that reseeds adds two setup products,
// a power for the multiplier, a power for the generator and the coprime
// search. Configuration writes take effect at once and belong to idle
// periods.
module random_packet_id_generator import rpid_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  rpid_req_if.sink         req,
  rpid_rsp_if.source       rsp
);

  cfg_t cfg_q;
  logic ov_q;
  rsp_t od_q;
  logic idle, done, start, slot_free;
  rsp_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.id_bits         <= 6'd32;
      cfg_q.cycle_limit     <= 32'd1000000000;
      cfg_q.prime_modulus   <= 32'd2147483629;
      cfg_q.base_generator  <= 32'd2;
      cfg_q.lcg_modulus     <= 32'd1836660096;
      cfg_q.multiplier_base <= 32'd7;
      cfg_q.reseed_interval <= 16'd180;
      cfg_q.large_factor    <= 32'd59652323;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgIdBits:     cfg_q.id_bits         <= cfg_data_i[5:0];
        CfgCycleLimit: cfg_q.cycle_limit     <= cfg_data_i;
        CfgPrimeMod:   cfg_q.prime_modulus   <= cfg_data_i;
        CfgBaseGen:    cfg_q.base_generator  <= cfg_data_i;
        CfgLcgMod:     cfg_q.lcg_modulus     <= cfg_data_i;
        CfgMultBase:   cfg_q.multiplier_base <= cfg_data_i;
        CfgInterval:   cfg_q.reseed_interval <= cfg_data_i[15:0];
        CfgLargeFact:  cfg_q.large_factor    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign req.ready = idle;
  assign start     = req.valid && idle;
  assign slot_free = !ov_q || rsp.ready;

  rpid_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .start_i(start), .req_i(req.data),
    .slot_free_i(slot_free), .done_o(done), .rsp_o(res), .idle_o(idle)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (done) begin
      ov_q <= 1'b1;
    end else if (rsp.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) od_q <= res;
  end

  assign rsp.valid = ov_q;
  assign rsp.data  = od_q;

  // The sequencer leaves idle once it takes an item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !idle) else $error("ready stayed high after an accepted item");

  // A finished item only hands over into a free output slot.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (!ov_q || rsp.ready)) else $error("result overwrote a pending item");

  // A new result appears only right after a handoff from the sequencer.
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(done)) else $error("output valid without a result");

endmodule
`default_nettype wire

// ===== sim/rpid_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module rpid_checker import rpid_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  rpid_req_if              req,
  rpid_rsp_if              rsp,
  output int               fail_cnt_o,
  output int               pending_o
);

  cfg_t        cfg;
  logic [31:0] lcg_q, oseed_q, eseed_q, mult_q, incr_q, gen_q, count_q, deadline_q;
  logic        flag_q;
  rsp_t        id_queue[$];

  function automatic logic [63:0] reduce(logic [63:0] v, logic [31:0] m);
    return (m == 32'd0) ? {32'd0, v[31:0]} : v % {32'd0, m};
  endfunction

  function automatic logic [31:0] pow_mod(logic [31:0] b, logic [31:0] e, logic [31:0] m);
    logic [63:0] s, t;
    s = 64'd1;
    t = {32'd0, b};
    while (e != 32'd0) begin
      if (e[0]) s = reduce(s * t, m);
      e = e >> 1;
      t = reduce(t * t, m);
    end
    return s[31:0];
  endfunction

  function automatic logic [31:0] ones(int unsigned n);
    return (n >= 32) ? 32'hFFFF_FFFF : (32'd1 << n) - 32'd1;
  endfunction

  function automatic bit shares_factor(logic [31:0] j);
    if (j % 3 == 0 || j[0] == 1'b0) return 1'b1;
    if (cfg.large_factor != 32'd0 && j % cfg.large_factor == 0) return 1'b1;
    return 1'b0;
  endfunction

  // Computes the id for one request and advances the generator state.
  function automatic rsp_t next_id(req_t r);
    int unsigned width;
    logic [31:0] b, j, id;
    rsp_t        res;
    width = cfg.id_bits < 2 ? 2 : (cfg.id_bits > WordWidth ? WordWidth : cfg.id_bits);
    res.did_reseed = (count_q >= cfg.cycle_limit) || (r.now_seconds > deadline_q) ||
                     ({1'b0, count_q} + r.skip_word >= {1'b0, cfg.cycle_limit});
    if (res.did_reseed) begin
      lcg_q   = 32'(reduce({32'd0, r.rand_state}, cfg.lcg_modulus));
      oseed_q = r.rand_seed_out & ones(width - 1);
      eseed_q = r.rand_seed_exp & ones(width - 1);
      b = (r.rand_increment & ones(width)) | 32'd1;
      while (b % 3 == 0) b = b + 32'd2;
      incr_q = b;
      mult_q = pow_mod(cfg.multiplier_base, (r.rand_mult_exp & ones(width)) & ~32'd1,
                       cfg.lcg_modulus);
      j = 32'(reduce({32'd0, r.rand_gen_exp}, cfg.prime_modulus));
      for (int k = 1; k < 64 && shares_factor(j); k++)
        j = 32'(reduce({32'd0, j} + 64'd1, cfg.prime_modulus));
      gen_q      = pow_mod(cfg.base_generator, j, cfg.prime_modulus);
      count_q    = 32'd0;
      deadline_q = r.now_seconds + cfg.reseed_interval;
      flag_q     = ~flag_q;
    end
    for (int i = 0; i <= r.skip_word; i++)
      lcg_q = 32'(reduce({32'd0, mult_q} * {32'd0, lcg_q} + {32'd0, incr_q},
                         cfg.lcg_modulus));
    count_q = count_q + r.skip_word + 32'd1;
    id = oseed_q ^ pow_mod(gen_q, eseed_q ^ lcg_q, cfg.prime_modulus);
    if (flag_q) id = id | (32'd1 << (width - 1));
    res.id_value = id & ones(width);
    return res;
  endfunction

  assign pending_o = id_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    int   errs;
    if (!rst_ni) begin
      cfg <= '{id_bits: 6'd32, cycle_limit: 32'd1000000000, prime_modulus: 32'd2147483629,
               base_generator: 32'd2, lcg_modulus: 32'd1836660096, multiplier_base: 32'd7,
               reseed_interval: 16'd180, large_factor: 32'd59652323};
      {lcg_q, oseed_q, eseed_q, mult_q, incr_q, gen_q, count_q, deadline_q} = '0;
      flag_q = 1'b0;
      fail_cnt_o <= 0;
      id_queue.delete();
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgIdBits:     cfg.id_bits <= cfg_data_i[5:0];
          CfgCycleLimit: cfg.cycle_limit <= cfg_data_i;
          CfgPrimeMod:   cfg.prime_modulus <= cfg_data_i;
          CfgBaseGen:    cfg.base_generator <= cfg_data_i;
          CfgLcgMod:     cfg.lcg_modulus <= cfg_data_i;
          CfgMultBase:   cfg.multiplier_base <= cfg_data_i;
          CfgInterval:   cfg.reseed_interval <= cfg_data_i[15:0];
          CfgLargeFact:  cfg.large_factor <= cfg_data_i;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (id_queue.size() == 0) begin
          $error("unexpected result item id_value=%h", rsp.data.id_value);
          errs++;
        end else begin
          want = id_queue.pop_front();
          if (want.id_value !== rsp.data.id_value) begin
            $error("id_value expected %h actual %h", want.id_value, rsp.data.id_value);
            errs++;
          end
          if (want.did_reseed !== rsp.data.did_reseed) begin
            $error("did_reseed expected %b actual %b", want.did_reseed, rsp.data.did_reseed);
            errs++;
          end
        end
      end
      fail_cnt_o <= fail_cnt_o + errs;
      if (req.valid && req.ready) id_queue.push_back(next_id(req.data));
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import rpid_pkg::*;

  localparam int IdleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_cnt, pending;
  int          idle_cycles = 0;
  int          hold_seq = 0;
  int          burst_left = 1;
  logic [31:0] clock_now = 32'd0;

  rpid_req_if req_if();
  rpid_rsp_if rsp_if();

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
  end

  always #2 clk_i = ~clk_i;

  random_packet_id_generator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .req(req_if), .rsp(rsp_if)
  );

  rpid_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .req(req_if), .rsp(rsp_if),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // Receiver: changes its stall pattern now and then, and holds off for a long
  // stretch whenever the stimulus asks for it.
  always @(posedge clk_i) begin
    int mode, mode_left, hold_left, seen_seq;
    if (hold_seq != seen_seq) begin
      seen_seq  = hold_seq;
      hold_left = 3000;
    end
    if (mode_left <= 0) begin
      mode      = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 400);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      case (mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= 1'($urandom_range(0, 1));
        default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("random_packet_id_generator test failed");
      $finish;
    end
  end

  task automatic send(req_t r);
    int gap;
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= v[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly a slowly advancing clock, so that reseeds come from the counter as
  // well as from the deadline; now and then a wild time value.
  function automatic req_t rand_req();
    req_t r;
    if ($urandom_range(0, 9) == 0) clock_now = $urandom();
    else clock_now = clock_now + $urandom_range(0, 3);
    r.now_seconds    = clock_now;
    r.skip_word      = 2'($urandom_range(0, 3));
    r.rand_state     = $urandom();
    r.rand_seed_out  = $urandom();
    r.rand_seed_exp  = $urandom();
    r.rand_increment = $urandom();
    r.rand_mult_exp  = $urandom();
    r.rand_gen_exp   = $urandom();
    return r;
  endfunction

  function automatic req_t fill_req(logic [31:0] now, logic [1:0] skip, logic [31:0] w);
    return '{now, skip, w, w, w, w, w, w};
  endfunction

  task automatic run_random(int n, bit with_hold);
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_seq++;
      send(rand_req());
    end
    drain();
  endtask

  initial begin
    logic [31:0] regs[8];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state first: no reseed at time zero, all state still zero.
    send(fill_req(32'd0, 2'd0, 32'd0));
    send(fill_req(32'd0, 2'd3, 32'hFFFF_FFFF));
    send(fill_req(32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF));
    send(fill_req(32'hFFFF_FFFF, 2'd0, 32'd0));
    send(fill_req(32'd0, 2'd1, 32'hAAAA_AAAA));
    send(fill_req(32'd181, 2'd2, 32'h5555_5555));
    drain();

    // Smallest settings; a search for j that never finds a coprime value.
    regs = '{32'd2, 32'd4, 32'd3, 32'd0, 32'd1, 32'd0, 32'd0, 32'd1};
    write_regs(regs);
    for (int i = 0; i < 8; i++) send(fill_req(32'(i / 2), 2'(i), $urandom()));
    drain();

    // Zero moduli stand for 2^32; a deadline that wraps past 2^32.
    regs = '{32'd63, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
             32'd65535, 32'd0};
    write_regs(regs);
    for (int i = 0; i < 8; i++)
      send(fill_req(32'hFFFF_FFF0 + 32'(i * 3), 2'(i), (i == 0) ? 32'd0 : $urandom()));
    drain();

    regs = '{32'd1, 32'd7, 32'd65521, 32'd3, 32'd1000003, 32'd5, 32'd10, 32'd5};
    write_regs(regs);
    run_random(30, 1'b0);

    regs = '{32'd16, 32'd40, 32'd4294967291, 32'd6, 32'd1 << 20, 32'd3, 32'd2, 32'd0};
    write_regs(regs);
    run_random(30, 1'b1);

    regs = '{32'd32, 32'd1000000000, 32'd2147483629, 32'd2, 32'd1836660096, 32'd7,
             32'd180, 32'd59652323};
    write_regs(regs);
    clock_now = 32'd0;
    run_random(30, 1'b0);

    regs = '{32'd24, 32'd12, 32'd1000003, 32'd2, 32'd65536, 32'd11, 32'd5, 32'd166667};
    write_regs(regs);
    run_random(30, 1'b1);

    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("random_packet_id_generator test passed");
    end else begin
      $display("random_packet_id_generator test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
